[rtl/pse_pkg.sv]
// ----------------------------------------------------------------------------
// pse_pkg: shared types and constants for the postfix stack evaluator
// Character codes, status codes, controller states and command structs.
// ----------------------------------------------------------------------------
package pse_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int SP_W  = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_DOLL  = 8'h24;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_OVERFLOW  = 3'd1;
    localparam logic [2:0] ST_UNDERFLOW = 3'd2;
    localparam logic [2:0] ST_INVALID   = 3'd3;
    localparam logic [2:0] ST_DIVZERO   = 3'd4;

    typedef enum logic [2:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_POW
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE, S_RD_TOP, S_WAIT_TOP, S_RD_L, S_WAIT_L, S_RD_R, S_WAIT_R,
        S_EXEC, S_RUN, S_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic clr_cnt;
        logic push_digit;   // write digit at count, count++
        logic rd_top;       // read entry count-1
        logic rd_second;    // read entry count-2
        logic lat_r;        // latch read data as right operand
        logic lat_l;        // latch read data as left operand
        logic start;        // launch op
        logic write_res;    // write result at count-2, count--
        t_op  op;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic             busy;
        logic             rhs_zero;
    } t_stat;

endpackage

[rtl/pse_if.sv]
// ----------------------------------------------------------------------------
// pse_sym_if / pse_res_if: valid/ready channels of the evaluator
// Input character channel and result channel.
// ----------------------------------------------------------------------------
interface pse_sym_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    modport source (output valid, output symbol, input ready);
    modport sink   (input valid, input symbol, output ready);
endinterface

interface pse_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic [2:0]         status;
    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

[rtl/pse_datapath.sv]
// ----------------------------------------------------------------------------
// pse_datapath: operand stack memory, operand registers and iterative ALU
// Divide runs one quotient bit per cycle; multiply and power use registered
// 32x32 multipliers; each square-and-multiply step registers its products first.
// ----------------------------------------------------------------------------
module pse_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pse_pkg::t_cmd        i_cmd,
    input  logic [3:0]           i_digit,
    output pse_pkg::t_stat       o_stat,
    output logic [31:0]          o_top
);
    logic [31:0] mem [pse_pkg::STACK_DEPTH];
    logic [31:0] r_rdata;
    logic [pse_pkg::CNT_W-1:0] r_cnt;
    logic [31:0] r_lhs, r_rhs, r_res;
    logic [31:0] r_base, r_exp;
    logic [31:0] r_rem, r_quo, r_dvs;
    logic [5:0]  r_step;
    logic        r_neg_q, r_neg_r;
    logic        r_busy, r_mulph;
    pse_pkg::t_op r_op;

    logic [pse_pkg::SP_W-1:0] rd_addr, wr_addr;
    logic [pse_pkg::CNT_W-1:0] cm1, cm2;
    logic [31:0] r_prod;
    logic [32:0] trial;

    assign cm1 = r_cnt - pse_pkg::CNT_W'(1);
    assign cm2 = r_cnt - pse_pkg::CNT_W'(2);
    assign rd_addr = i_cmd.rd_second ? cm2[pse_pkg::SP_W-1:0] : cm1[pse_pkg::SP_W-1:0];
    assign wr_addr = i_cmd.push_digit ? r_cnt[pse_pkg::SP_W-1:0] : cm2[pse_pkg::SP_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_digit)
            mem[wr_addr] <= {28'd0, i_digit};
        else if (i_cmd.write_res)
            mem[wr_addr] <= r_res;
        if (i_cmd.rd_top || i_cmd.rd_second)
            r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.clr_cnt) begin
            r_cnt <= '0;
        end else if (i_cmd.push_digit) begin
            r_cnt <= r_cnt + pse_pkg::CNT_W'(1);
        end else if (i_cmd.write_res) begin
            r_cnt <= cm1;
        end
    end

    assign trial = {1'b0, r_rem[30:0], r_quo[31]} - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_cmd.start) begin
            r_busy  <= 1'b1;
            r_op    <= i_cmd.op;
            r_mulph <= 1'b0;
            r_step  <= '0;
            r_neg_q <= r_lhs[31] ^ r_rhs[31];
            r_neg_r <= r_lhs[31];
            r_quo   <= r_lhs[31] ? -r_lhs : r_lhs;
            r_dvs   <= r_rhs[31] ? -r_rhs : r_rhs;
            r_rem   <= '0;
            r_base  <= r_lhs;
            r_exp   <= r_rhs;
            r_res   <= 32'd1;
        end else if (r_busy) begin
            unique case (r_op)
                pse_pkg::OP_ADD: begin
                    r_res  <= r_lhs + r_rhs;
                    r_busy <= 1'b0;
                end
                pse_pkg::OP_SUB: begin
                    r_res  <= r_lhs - r_rhs;
                    r_busy <= 1'b0;
                end
                pse_pkg::OP_MUL: begin
                    if (!r_mulph) begin
                        r_prod  <= r_lhs * r_rhs;
                        r_mulph <= 1'b1;
                    end else begin
                        r_res  <= r_prod;
                        r_busy <= 1'b0;
                    end
                end
                pse_pkg::OP_DIV, pse_pkg::OP_MOD: begin
                    if (r_step == 6'd32) begin
                        if (r_op == pse_pkg::OP_DIV)
                            r_res <= r_neg_q ? -r_quo : r_quo;
                        else
                            r_res <= r_neg_r ? -r_rem : r_rem;
                        r_busy <= 1'b0;
                    end else begin
                        if (!trial[32]) begin
                            r_rem <= trial[31:0];
                            r_quo <= {r_quo[30:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[30:0], r_quo[31]};
                            r_quo <= {r_quo[30:0], 1'b0};
                        end
                        r_step <= r_step + 6'd1;
                    end
                end
                default: begin // power
                    if (r_exp[31]) begin
                        if (r_base == 32'd1)
                            r_res <= 32'd1;
                        else if (r_base == 32'hFFFF_FFFF)
                            r_res <= r_exp[0] ? 32'hFFFF_FFFF : 32'd1;
                        else
                            r_res <= 32'd0;
                        r_busy <= 1'b0;
                    end else if (r_exp == 32'd0) begin
                        r_busy <= 1'b0;
                    end else if (!r_mulph) begin
                        r_prod  <= r_res * r_base;
                        r_quo   <= r_base * r_base;
                        r_mulph <= 1'b1;
                    end else begin
                        if (r_exp[0])
                            r_res <= r_prod;
                        r_base  <= r_quo;
                        r_exp   <= r_exp >> 1;
                        r_mulph <= 1'b0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lat_r)
            r_rhs <= r_rdata;
        if (i_cmd.lat_l)
            r_lhs <= r_rdata;
    end

    assign o_stat.cnt      = r_cnt;
    assign o_stat.busy     = r_busy;
    assign o_stat.rhs_zero = (r_rhs == 32'd0);
    assign o_top           = r_rdata;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= pse_pkg::CNT_W'(pse_pkg::STACK_DEPTH))
        else $error("stack count past depth");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push_digit |-> r_cnt < pse_pkg::CNT_W'(pse_pkg::STACK_DEPTH))
        else $error("push on full stack");
    a_pop_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write_res |-> r_cnt >= pse_pkg::CNT_W'(2))
        else $error("result write with short stack");
endmodule

[rtl/pse_ctrl.sv]
// ----------------------------------------------------------------------------
// pse_ctrl: character decode and sequencing FSM
// Classifies each character, drives the datapath and forms result items.
// ----------------------------------------------------------------------------
module pse_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    pse_sym_if.sink        sym,
    pse_res_if.source      res,
    output pse_pkg::t_cmd  o_cmd,
    output logic [3:0]     o_digit,
    input  pse_pkg::t_stat i_stat,
    input  logic [31:0]    i_top
);
    pse_pkg::t_state r_state, n_state;
    logic        r_err, n_err;
    logic        r_ovalid, n_ovalid;
    logic [31:0] r_oval, n_oval;
    logic [2:0]  r_ost, n_ost;
    pse_pkg::t_op r_op, n_op;
    logic        accept, is_digit, is_op, out_free;
    pse_pkg::t_op dec_op;

    assign out_free = !r_ovalid || res.ready;
    assign accept   = sym.valid && sym.ready;
    assign is_digit = sym.symbol >= pse_pkg::CH_ZERO && sym.symbol <= pse_pkg::CH_NINE;
    assign o_digit  = sym.symbol[3:0];

    always_comb begin
        is_op  = 1'b1;
        dec_op = pse_pkg::OP_ADD;
        case (sym.symbol)
            pse_pkg::CH_PLUS:  dec_op = pse_pkg::OP_ADD;
            pse_pkg::CH_MINUS: dec_op = pse_pkg::OP_SUB;
            pse_pkg::CH_STAR:  dec_op = pse_pkg::OP_MUL;
            pse_pkg::CH_SLASH: dec_op = pse_pkg::OP_DIV;
            pse_pkg::CH_PCT:   dec_op = pse_pkg::OP_MOD;
            pse_pkg::CH_DOLL:  dec_op = pse_pkg::OP_POW;
            default:           is_op  = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pse_pkg::S_IDLE;
            r_err    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_err    <= n_err;
            r_ovalid <= n_ovalid;
        end
        r_oval <= n_oval;
        r_ost  <= n_ost;
        r_op   <= n_op;
    end

    always_comb begin
        n_state  = r_state;
        n_err    = r_err;
        n_ovalid = r_ovalid;
        n_oval   = r_oval;
        n_ost    = r_ost;
        n_op     = r_op;
        o_cmd    = '0;
        o_cmd.op = r_op;
        sym.ready = 1'b0;
        if (res.ready)
            n_ovalid = 1'b0;
        unique case (r_state)
            pse_pkg::S_IDLE: begin
                sym.ready = out_free;
                if (accept) begin
                    if (sym.symbol == pse_pkg::CH_NUL) begin
                        o_cmd.clr_cnt = 1'b1;
                        n_err = 1'b0;
                        if (!r_err) begin
                            if (i_stat.cnt == '0) begin
                                n_ovalid = 1'b1;
                                n_oval   = '0;
                                n_ost    = pse_pkg::ST_UNDERFLOW;
                            end else begin
                                o_cmd.rd_top = 1'b1;
                                o_cmd.clr_cnt = 1'b0;
                                n_state = pse_pkg::S_WAIT_TOP;
                            end
                        end
                    end else if (!r_err) begin
                        if (is_digit) begin
                            if (i_stat.cnt == pse_pkg::CNT_W'(pse_pkg::STACK_DEPTH)) begin
                                n_err = 1'b1; n_ovalid = 1'b1;
                                n_oval = '0; n_ost = pse_pkg::ST_OVERFLOW;
                            end else begin
                                o_cmd.push_digit = 1'b1;
                            end
                        end else if (i_stat.cnt < pse_pkg::CNT_W'(2)) begin
                            n_err = 1'b1; n_ovalid = 1'b1;
                            n_oval = '0; n_ost = pse_pkg::ST_UNDERFLOW;
                        end else if (!is_op) begin
                            n_err = 1'b1; n_ovalid = 1'b1;
                            n_oval = '0; n_ost = pse_pkg::ST_INVALID;
                        end else begin
                            n_op = dec_op;
                            o_cmd.rd_top = 1'b1;
                            n_state = pse_pkg::S_WAIT_R;
                        end
                    end
                end
            end
            pse_pkg::S_WAIT_TOP: begin
                o_cmd.clr_cnt = 1'b1;
                n_state = pse_pkg::S_OUT;
            end
            pse_pkg::S_OUT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_oval   = i_top;
                    n_ost    = pse_pkg::ST_OK;
                    n_state  = pse_pkg::S_IDLE;
                end
            end
            pse_pkg::S_WAIT_R: begin
                o_cmd.lat_r = 1'b1;
                o_cmd.rd_second = 1'b1;
                n_state = pse_pkg::S_WAIT_L;
            end
            pse_pkg::S_WAIT_L: begin
                o_cmd.lat_l = 1'b1;
                n_state = pse_pkg::S_EXEC;
            end
            pse_pkg::S_EXEC: begin
                if ((r_op == pse_pkg::OP_DIV || r_op == pse_pkg::OP_MOD)
                        && i_stat.rhs_zero) begin
                    if (out_free) begin
                        n_err = 1'b1; n_ovalid = 1'b1;
                        n_oval = '0; n_ost = pse_pkg::ST_DIVZERO;
                        n_state = pse_pkg::S_IDLE;
                    end
                end else begin
                    o_cmd.start = 1'b1;
                    n_state = pse_pkg::S_RUN;
                end
            end
            pse_pkg::S_RUN: begin
                if (!i_stat.busy) begin
                    o_cmd.write_res = 1'b1;
                    n_state = pse_pkg::S_IDLE;
                end
            end
            default: n_state = pse_pkg::S_IDLE;
        endcase
    end

    assign res.valid  = r_ovalid;
    assign res.value  = r_oval;
    assign res.status = r_ost;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_ost != pse_pkg::ST_OK |-> r_oval == '0)
        else $error("error result with nonzero value");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !res.ready |=> r_ovalid && $stable(r_oval) && $stable(r_ost))
        else $error("result changed under stall");
    a_busy_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != pse_pkg::S_IDLE |-> !sym.ready)
        else $error("input taken while busy");
endmodule

[rtl/postfix_stack_evaluator.sv]
// ----------------------------------------------------------------------------
// postfix_stack_evaluator: streaming RPN integer expression evaluator
// Top level joining the sequencing controller and the stack datapath.
// ----------------------------------------------------------------------------
// Usage:
//   sym channel: one ASCII character per transaction. Digits push 0..9;
//   + - * / % $ pop right then left operand and push the 32-bit wrapped
//   result. A zero byte ends the expression and yields one result
//   transaction on res (value, status). The first error yields one error
//   transaction (value 0) and later characters are dropped up to and
//   including the terminator, which then yields nothing.
// Sequencing: a digit or an error found at decode is handled in S_IDLE; a
//   zero divisor is found after the operand fetch (S_WAIT_R, S_WAIT_L).
//   / and % use the shift-subtract divider, one quotient bit per cycle;
//   $ runs square-and-multiply steps on two registered multipliers. A
//   terminator reads the top entry through S_WAIT_TOP and S_OUT, or is
//   done in S_IDLE on an empty stack or under a held error.
// Reset: synchronous active low; empties the stack and clears the error
//   hold. Stack RAM contents are not cleared.
// Stall: the result sits in an output register; no character is taken
//   while it waits, except in the cycle in which it is taken.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pse_sym_if.sink   sym,
    pse_res_if.source res
);
    pse_pkg::t_cmd  cmd;
    pse_pkg::t_stat stat;
    logic [3:0]     digit;
    logic [31:0]    top;

    pse_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .sym     (sym),
        .res     (res),
        .o_cmd   (cmd),
        .o_digit (digit),
        .i_stat  (stat),
        .i_top   (top)
    );

    pse_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_digit (digit),
        .o_stat  (stat),
        .o_top   (top)
    );
endmodule
